/* hdl/cpu8_alu_flags_unit_defines.svh */
// Assertion macros shared by the ALU flag unit RTL.
// Included by bare file name; no other dependencies.
`ifndef CPU8_ALU_FLAGS_UNIT_DEFINES_SVH
`define CPU8_ALU_FLAGS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define C8ALU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define C8ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/c8alu_pkg.sv */
// Types, codes and flag helpers for the 8-bit ALU flag unit.
// No dependencies; imported by every module of the block.
package c8alu_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        OP_AND    = 5'd0,
        OP_ORA    = 5'd1,
        OP_EOR    = 5'd2,
        OP_ADC    = 5'd3,
        OP_SBC    = 5'd4,
        OP_BIT    = 5'd5,
        OP_CMP    = 5'd6,
        OP_LD     = 5'd7,
        OP_ASL    = 5'd8,
        OP_LSR    = 5'd9,
        OP_ROL    = 5'd10,
        OP_ROR    = 5'd11,
        OP_INC    = 5'd12,
        OP_DEC    = 5'd13,
        OP_XFER   = 5'd14,
        OP_BRTEST = 5'd15,
        OP_SETF   = 5'd16,
        OP_CLRF   = 5'd17
    } t_opcode;

    // Register select codes
    localparam logic [1:0] REG_A   = 2'd0;
    localparam logic [1:0] REG_X   = 2'd1;
    localparam logic [1:0] REG_Y   = 2'd2;
    localparam logic [1:0] REG_MEM = 2'd3;

    // Branch condition codes
    localparam logic [2:0] CC_C_CLR = 3'd0;
    localparam logic [2:0] CC_C_SET = 3'd1;
    localparam logic [2:0] CC_Z_SET = 3'd2;
    localparam logic [2:0] CC_Z_CLR = 3'd3;
    localparam logic [2:0] CC_N_SET = 3'd4;
    localparam logic [2:0] CC_N_CLR = 3'd5;
    localparam logic [2:0] CC_V_SET = 3'd6;
    localparam logic [2:0] CC_V_CLR = 3'd7;

    // Flag select codes
    localparam logic [2:0] FS_C = 3'd0;
    localparam logic [2:0] FS_Z = 3'd1;
    localparam logic [2:0] FS_I = 3'd2;
    localparam logic [2:0] FS_V = 3'd3;
    localparam logic [2:0] FS_N = 3'd4;
    localparam logic [2:0] FS_B = 3'd5;

    // Status bit masks, layout N V - B D I Z C
    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    typedef struct packed {
        logic [4:0] opcode;
        logic [7:0] operand;
        logic [1:0] target_reg;
        logic [1:0] source_reg;
        logic [2:0] cond_code;
        logic [2:0] flag_sel;
    } t_item;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] status_out;
        logic [7:0] mem_value;
        logic       mem_write;
        logic       branch_taken;
    } t_result;

    // Mask for a flag select code; unused codes give no bit
    function automatic logic [7:0] flag_mask(input logic [2:0] fsel);
        logic [7:0] m;
        case (fsel)
            FS_C:    m = FLAG_C;
            FS_Z:    m = FLAG_Z;
            FS_I:    m = FLAG_I;
            FS_V:    m = FLAG_V;
            FS_N:    m = FLAG_N;
            FS_B:    m = FLAG_B;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Force the masked bits of a status byte to one value
    function automatic logic [7:0] put_flag(input logic [7:0] st, input logic [7:0] mask,
                                            input logic on);
        return on ? (st | mask) : (st & ~mask);
    endfunction

    // Update N and Z from a result byte
    function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] v);
        logic [7:0] s;
        s = put_flag(st, FLAG_N, v[7]);
        s = put_flag(s, FLAG_Z, v == 8'h00);
        return s;
    endfunction

endpackage

/* hdl/cpu8_alu_flags_unit.sv */
// Top level of the 8-bit ALU and status flag unit.
// Depends on c8alu_pkg, c8alu_in_stage, c8alu_core, c8alu_out_stage and the defines header.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   opcode operand target_reg source_reg
//                                                 cond_code flag_sel
//   out      source     o_out_valid / i_out_stall acc_out x_out y_out status_out
//                                                 mem_value mem_write branch_taken
//
// An input beat passes the input register, then the result register; one beat per
// cycle sustained while the output is not stalled. The ALU sits between these two
// registers, and A, X, Y and status commit as a beat moves into the result register,
// so the next beat sees them directly. Synchronous active-low reset clears A, X, Y,
// status and the valids, not the payloads. A stalled output holds the result; the input
// register still empties into a freed result register in the same cycle the old beat is taken.
`include "cpu8_alu_flags_unit_defines.svh"

module cpu8_alu_flags_unit import c8alu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [4:0] i_opcode,
    input  logic [7:0] i_operand,
    input  logic [1:0] i_target_reg,
    input  logic [1:0] i_source_reg,
    input  logic [2:0] i_cond_code,
    input  logic [2:0] i_flag_sel,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_x_out,
    output logic [7:0] o_y_out,
    output logic [7:0] o_status_out,
    output logic [7:0] o_mem_value,
    output logic       o_mem_write,
    output logic       o_branch_taken
);

    t_item   in_item;
    t_item   s1_item;
    logic    s1_valid;
    logic    out_free;
    logic    adv;
    t_result core_res;
    t_result out_res;

    // Pack the input beat
    assign in_item.opcode     = i_opcode;
    assign in_item.operand    = i_operand;
    assign in_item.target_reg = i_target_reg;
    assign in_item.source_reg = i_source_reg;
    assign in_item.cond_code  = i_cond_code;
    assign in_item.flag_sel   = i_flag_sel;

    // Advance when a beat is held and the result register can take it
    assign adv = s1_valid && out_free;

    c8alu_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_adv   (adv),
        .o_stall (o_in_stall),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    c8alu_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (s1_item),
        .o_res   (core_res)
    );

    c8alu_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (core_res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    // Unpack the result beat
    assign o_acc_out      = out_res.acc_out;
    assign o_x_out        = out_res.x_out;
    assign o_y_out        = out_res.y_out;
    assign o_status_out   = out_res.status_out;
    assign o_mem_value    = out_res.mem_value;
    assign o_mem_write    = out_res.mem_write;
    assign o_branch_taken = out_res.branch_taken;

    // A beat that advances shows up at the output next cycle
    `C8ALU_ASSERT_NEXT(a_adv_to_out, i_clk, i_rst_n, adv, o_out_valid, "advanced beat lost")
    // Write-back value is zero unless a write is flagged
    `C8ALU_ASSERT_NOW(a_mem_zero, i_clk, i_rst_n, o_out_valid && !o_mem_write,
                      o_mem_value == 8'h00, "stray write-back value")
    // A memory write and a taken branch never come from the same operation
    `C8ALU_ASSERT_NOW(a_wr_vs_br, i_clk, i_rst_n, o_out_valid && o_mem_write,
                      !o_branch_taken, "write-back with taken branch")
    // D and the unused status bit are never set
    `C8ALU_ASSERT_NOW(a_status_fixed, i_clk, i_rst_n, o_out_valid,
                      o_status_out[3] == 1'b0 && o_status_out[5] == 1'b0,
                      "reserved status bit set")

endmodule

/* hdl/c8alu_in_stage.sv */
// Input register of the ALU flag unit: holds one accepted beat.
// Depends on c8alu_pkg for the item type.
module c8alu_in_stage import c8alu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_adv,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    // Stall only while a held beat cannot move on
    assign o_stall = r_valid && !i_adv;
    assign load    = i_valid && !o_stall;

    // Refill or drain the slot
    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hdl/c8alu_core.sv */
// ALU and architectural registers A, X, Y and status.
// Depends on c8alu_pkg; computes one operation per advancing beat.
module c8alu_core import c8alu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_res
);

    logic [7:0] r_acc, r_x, r_y, r_status;
    logic [7:0] n_acc, n_x, n_y, n_status;
    logic [7:0] mem_value;
    logic       mem_write;
    logic       taken;
    logic [7:0] m;
    logic [7:0] tgt_val;
    logic [7:0] src_val;
    logic [7:0] add_b;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] sh_in;
    logic [7:0] sh_res;
    logic       sh_cout;
    logic [7:0] id_in;
    logic [7:0] id_res;
    logic       flag_now;
    logic       want_set;
    logic       wr_en;
    logic [7:0] wr_val;

    assign m = i_item.operand;

    // Select the target and source register values
    always_comb begin
        case (i_item.target_reg)
            REG_A:   tgt_val = r_acc;
            REG_X:   tgt_val = r_x;
            REG_Y:   tgt_val = r_y;
            default: tgt_val = m;
        endcase
        case (i_item.source_reg)
            REG_A:   src_val = r_acc;
            REG_X:   src_val = r_x;
            default: src_val = r_y;
        endcase
    end

    // Binary adder for ADC and SBC, subtractor for compare
    assign add_b = (t_opcode'(i_item.opcode) == OP_SBC) ? ~m : m;
    assign sum   = {1'b0, r_acc} + {1'b0, add_b} + {8'h00, r_status[0]};
    assign diff  = {1'b0, tgt_val} - {1'b0, m};

    // Shift and rotate datapath, A or memory operand
    assign sh_in = (i_item.target_reg == REG_A) ? r_acc : m;
    always_comb begin
        case (t_opcode'(i_item.opcode))
            OP_ASL:  begin sh_res = {sh_in[6:0], 1'b0};        sh_cout = sh_in[7]; end
            OP_ROL:  begin sh_res = {sh_in[6:0], r_status[0]}; sh_cout = sh_in[7]; end
            OP_LSR:  begin sh_res = {1'b0, sh_in[7:1]};        sh_cout = sh_in[0]; end
            default: begin sh_res = {r_status[0], sh_in[7:1]}; sh_cout = sh_in[0]; end
        endcase
    end

    // Increment and decrement
    assign id_in  = tgt_val;
    assign id_res = (t_opcode'(i_item.opcode) == OP_INC) ? id_in + 8'd1 : id_in - 8'd1;

    // Branch test: pick the flag, then the wanted polarity
    always_comb begin
        case (i_item.cond_code)
            CC_C_CLR, CC_C_SET: flag_now = |(r_status & FLAG_C);
            CC_Z_SET, CC_Z_CLR: flag_now = |(r_status & FLAG_Z);
            CC_N_SET, CC_N_CLR: flag_now = |(r_status & FLAG_N);
            default:            flag_now = |(r_status & FLAG_V);
        endcase
        case (i_item.cond_code)
            CC_C_SET, CC_Z_SET, CC_N_SET, CC_V_SET: want_set = 1'b1;
            default:                               want_set = 1'b0;
        endcase
    end

    // Operation decode: next status, register write and memory write-back
    always_comb begin
        n_status  = r_status;
        mem_value = 8'h00;
        mem_write = 1'b0;
        taken     = 1'b0;
        wr_en     = 1'b0;
        wr_val    = 8'h00;
        n_acc     = r_acc;
        case (t_opcode'(i_item.opcode))
            OP_AND: begin
                n_acc    = r_acc & m;
                n_status = set_nz(r_status, r_acc & m);
            end
            OP_ORA: begin
                n_acc    = r_acc | m;
                n_status = set_nz(r_status, r_acc | m);
            end
            OP_EOR: begin
                n_acc    = r_acc ^ m;
                n_status = set_nz(r_status, r_acc ^ m);
            end
            OP_ADC, OP_SBC: begin
                n_acc    = sum[7:0];
                n_status = put_flag(r_status, FLAG_V,
                                    ~(r_acc[7] ^ add_b[7]) & (r_acc[7] ^ sum[7]));
                n_status = put_flag(n_status, FLAG_C, sum[8]);
                n_status = set_nz(n_status, sum[7:0]);
            end
            OP_BIT: begin
                n_status = put_flag(r_status, FLAG_N, m[7]);
                n_status = put_flag(n_status, FLAG_V, m[6]);
                n_status = put_flag(n_status, FLAG_Z, (r_acc & m) == 8'h00);
            end
            OP_CMP: begin
                if (i_item.target_reg != REG_MEM) begin
                    n_status = put_flag(r_status, FLAG_C, !diff[8]);
                    n_status = put_flag(n_status, FLAG_Z, tgt_val == m);
                    n_status = put_flag(n_status, FLAG_N, diff[7]);
                end
            end
            OP_LD: begin
                if (i_item.target_reg != REG_MEM) begin
                    wr_en    = 1'b1;
                    wr_val   = m;
                    n_status = set_nz(r_status, m);
                end
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                if (i_item.target_reg == REG_A || i_item.target_reg == REG_MEM) begin
                    n_status = put_flag(r_status, FLAG_C, sh_cout);
                    n_status = set_nz(n_status, sh_res);
                    if (i_item.target_reg == REG_A) begin
                        n_acc = sh_res;
                    end else begin
                        mem_value = sh_res;
                        mem_write = 1'b1;
                    end
                end
            end
            OP_INC, OP_DEC: begin
                n_status = set_nz(r_status, id_res);
                if (i_item.target_reg == REG_MEM) begin
                    mem_value = id_res;
                    mem_write = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    wr_val = id_res;
                end
            end
            OP_XFER: begin
                if (i_item.target_reg != REG_MEM && i_item.source_reg != REG_MEM) begin
                    wr_en    = 1'b1;
                    wr_val   = src_val;
                    n_status = set_nz(r_status, src_val);
                end
            end
            OP_BRTEST: begin
                taken = (flag_now == want_set);
            end
            OP_SETF: begin
                n_status = r_status | flag_mask(i_item.flag_sel);
            end
            OP_CLRF: begin
                n_status = r_status & ~flag_mask(i_item.flag_sel);
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    // Route register writes to A, X or Y
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (wr_en) begin
            case (i_item.target_reg)
                REG_X:   n_x = wr_val;
                REG_Y:   n_y = wr_val;
                default: ;
            endcase
        end
    end

    // A takes the routed write when targeted, otherwise the decode value
    logic [7:0] n_acc_w;
    assign n_acc_w = (wr_en && i_item.target_reg == REG_A) ? wr_val : n_acc;

    // Commit state as the beat advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 8'h00;
            r_x      <= 8'h00;
            r_y      <= 8'h00;
            r_status <= 8'h00;
        end else if (i_adv) begin
            r_acc    <= n_acc_w;
            r_x      <= n_x;
            r_y      <= n_y;
            r_status <= n_status;
        end
    end

    assign o_res.acc_out      = n_acc_w;
    assign o_res.x_out        = n_x;
    assign o_res.y_out        = n_y;
    assign o_res.status_out   = n_status;
    assign o_res.mem_value    = mem_value;
    assign o_res.mem_write    = mem_write;
    assign o_res.branch_taken = taken;

endmodule

/* hdl/c8alu_out_stage.sv */
// Result register of the ALU flag unit: holds one beat until taken.
// Depends on c8alu_pkg for the result type.
module c8alu_out_stage import c8alu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture result on load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* bench/cpu8_alu_flags_unit_tb.sv */
// Self-checking bench for cpu8_alu_flags_unit: directed and random ALU steps with a
// shadow copy of A, X, Y and status, checked beat by beat on the result channel.
// Depends on c8alu_pkg and the cpu8_alu_flags_unit RTL.
module cpu8_alu_flags_unit_tb import c8alu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_IDLE        = 14;
    localparam int         CYCLE_LIMIT     = 200_000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         RANDOM_CHUNKS   = 25;
    localparam int         CHUNK_BEATS     = 41;
    localparam logic [4:0] OPC_SPARE_FIRST = 5'd18;
    localparam logic [4:0] OPC_SPARE_LAST  = 5'd31;
    localparam logic [2:0] FSEL_SPARE_LAST = 3'd7;

    // Shadow of the programmer-visible state and the queue of awaited result beats
    class alu_state_tracker;
        logic [7:0] regs [3];
        logic [7:0] status;
        t_result    awaited [$];
        int         mismatches;

        function new();
            regs       = '{default: 8'h00};
            status     = 8'h00;
            mismatches = 0;
        endfunction

        function void assign_flag(logic [7:0] mask, logic on);
            status = on ? (status | mask) : (status & ~mask);
        endfunction

        function void update_nz(logic [7:0] v);
            assign_flag(FLAG_N, v[7]);
            assign_flag(FLAG_Z, v == 8'h00);
        endfunction

        // Execute one instruction on the shadow state and queue the beat it must give
        function void note_instruction(t_item it);
            logic [7:0] m;
            logic [7:0] v;
            logic [7:0] res;
            logic [7:0] diff;
            logic [7:0] mask;
            logic [8:0] sum;
            logic       want_set;
            t_result    r;
            m = it.operand;
            r = '0;
            case (it.opcode)
                OP_AND: begin
                    regs[REG_A] = regs[REG_A] & m;
                    update_nz(regs[REG_A]);
                end
                OP_ORA: begin
                    regs[REG_A] = regs[REG_A] | m;
                    update_nz(regs[REG_A]);
                end
                OP_EOR: begin
                    regs[REG_A] = regs[REG_A] ^ m;
                    update_nz(regs[REG_A]);
                end
                OP_ADC, OP_SBC: begin
                    // subtract is add of the inverted operand, borrow is not-carry
                    if (it.opcode == OP_SBC) m = ~m;
                    sum = {1'b0, regs[REG_A]} + {1'b0, m} + {8'h00, status[0]};
                    res = sum[7:0];
                    assign_flag(FLAG_V, (regs[REG_A][7] == m[7]) && (res[7] != m[7]));
                    assign_flag(FLAG_C, sum[8]);
                    regs[REG_A] = res;
                    update_nz(res);
                end
                OP_BIT: begin
                    assign_flag(FLAG_N, m[7]);
                    assign_flag(FLAG_V, m[6]);
                    assign_flag(FLAG_Z, (regs[REG_A] & m) == 8'h00);
                end
                OP_CMP: begin
                    if (it.target_reg != REG_MEM) begin
                        v    = regs[it.target_reg];
                        diff = v - m;
                        assign_flag(FLAG_C, v >= m);
                        assign_flag(FLAG_Z, v == m);
                        assign_flag(FLAG_N, diff[7]);
                    end
                end
                OP_LD: begin
                    if (it.target_reg != REG_MEM) begin
                        regs[it.target_reg] = m;
                        update_nz(m);
                    end
                end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    // shifts act on A or the operand only; X and Y targets do nothing
                    if (it.target_reg == REG_A || it.target_reg == REG_MEM) begin
                        v = (it.target_reg == REG_A) ? regs[REG_A] : m;
                        if (it.opcode == OP_ASL || it.opcode == OP_ROL) begin
                            res = {v[6:0], (it.opcode == OP_ROL) ? status[0] : 1'b0};
                            assign_flag(FLAG_C, v[7]);
                        end else begin
                            res = {(it.opcode == OP_ROR) ? status[0] : 1'b0, v[7:1]};
                            assign_flag(FLAG_C, v[0]);
                        end
                        update_nz(res);
                        if (it.target_reg == REG_A) begin
                            regs[REG_A] = res;
                        end else begin
                            r.mem_value = res;
                            r.mem_write = 1'b1;
                        end
                    end
                end
                OP_INC, OP_DEC: begin
                    v   = (it.target_reg != REG_MEM) ? regs[it.target_reg] : m;
                    res = (it.opcode == OP_INC) ? v + 8'h01 : v - 8'h01;
                    update_nz(res);
                    if (it.target_reg != REG_MEM) begin
                        regs[it.target_reg] = res;
                    end else begin
                        r.mem_value = res;
                        r.mem_write = 1'b1;
                    end
                end
                OP_XFER: begin
                    if (it.target_reg != REG_MEM && it.source_reg != REG_MEM) begin
                        regs[it.target_reg] = regs[it.source_reg];
                        update_nz(regs[it.target_reg]);
                    end
                end
                OP_BRTEST: begin
                    case (it.cond_code)
                        CC_C_CLR, CC_C_SET: mask = FLAG_C;
                        CC_Z_SET, CC_Z_CLR: mask = FLAG_Z;
                        CC_N_SET, CC_N_CLR: mask = FLAG_N;
                        default:            mask = FLAG_V;
                    endcase
                    want_set = (it.cond_code == CC_C_SET) || (it.cond_code == CC_Z_SET) ||
                               (it.cond_code == CC_N_SET) || (it.cond_code == CC_V_SET);
                    r.branch_taken = ((status & mask) != 8'h00) == want_set;
                end
                OP_SETF, OP_CLRF: begin
                    case (it.flag_sel)
                        FS_C:    mask = FLAG_C;
                        FS_Z:    mask = FLAG_Z;
                        FS_I:    mask = FLAG_I;
                        FS_V:    mask = FLAG_V;
                        FS_N:    mask = FLAG_N;
                        FS_B:    mask = FLAG_B;
                        default: mask = 8'h00;
                    endcase
                    status = (it.opcode == OP_SETF) ? (status | mask) : (status & ~mask);
                end
                default: ;
            endcase
            r.acc_out    = regs[REG_A];
            r.x_out      = regs[REG_X];
            r.y_out      = regs[REG_Y];
            r.status_out = status;
            awaited.push_back(r);
        endfunction

        function void compare_field(string fld, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %02h, got %02h", fld, want, got);
                mismatches++;
            end
        endfunction

        // Match a result beat against the oldest awaited one
        function void check_step_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result beat with no instruction outstanding");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("acc_out",      want.acc_out,      got.acc_out);
            compare_field("x_out",        want.x_out,        got.x_out);
            compare_field("y_out",        want.y_out,        got.y_out);
            compare_field("status_out",   want.status_out,   got.status_out);
            compare_field("mem_value",    want.mem_value,    got.mem_value);
            compare_field("mem_write",    {7'h00, want.mem_write},    {7'h00, got.mem_write});
            compare_field("branch_taken", {7'h00, want.branch_taken}, {7'h00, got.branch_taken});
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [4:0] in_opcode     = '0;
    logic [7:0] in_operand    = '0;
    logic [1:0] in_target_reg = '0;
    logic [1:0] in_source_reg = '0;
    logic [2:0] in_cond_code  = '0;
    logic [2:0] in_flag_sel   = '0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] status_out;
    logic [7:0] mem_value;
    logic       mem_write;
    logic       branch_taken;

    logic             in_idle  = 1'b1;
    logic             out_idle = 1'b1;
    int               cycles   = 0;
    alu_state_tracker alu;

    cpu8_alu_flags_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (in_opcode),
        .i_operand      (in_operand),
        .i_target_reg   (in_target_reg),
        .i_source_reg   (in_source_reg),
        .i_cond_code    (in_cond_code),
        .i_flag_sel     (in_flag_sel),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_acc_out      (acc_out),
        .o_x_out        (x_out),
        .o_y_out        (y_out),
        .o_status_out   (status_out),
        .o_mem_value    (mem_value),
        .o_mem_write    (mem_write),
        .o_branch_taken (branch_taken)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_item instr(logic [4:0] op, logic [7:0] m, logic [1:0] tgt,
                                    logic [1:0] src, logic [2:0] cc, logic [2:0] fs);
        t_item it;
        it.opcode     = op;
        it.operand    = m;
        it.target_reg = tgt;
        it.source_reg = src;
        it.cond_code  = cc;
        it.flag_sel   = fs;
        return it;
    endfunction

    function automatic t_item random_instr();
        t_item it;
        // mostly defined operations, a few spare codes
        if ($urandom_range(0, 9) == 0)
            it.opcode = 5'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST));
        else
            it.opcode = 5'($urandom_range(OP_AND, OP_CLRF));
        case ($urandom_range(0, 7))
            0:       it.operand = 8'h00;
            1:       it.operand = 8'hFF;
            2:       it.operand = 8'h7F;
            3:       it.operand = 8'h80;
            default: it.operand = 8'($urandom_range(0, 255));
        endcase
        it.target_reg = 2'($urandom_range(REG_A, REG_MEM));
        it.source_reg = 2'($urandom_range(REG_A, REG_MEM));
        it.cond_code  = 3'($urandom_range(CC_C_CLR, CC_V_CLR));
        it.flag_sel   = 3'($urandom_range(FS_C, FSEL_SPARE_LAST));
        return it;
    endfunction

    // Present one beat after an optional gap and hold it until taken
    task automatic issue_instruction(input t_item it);
        int gap;
        gap = in_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_opcode     <= it.opcode;
        in_operand    <= it.operand;
        in_target_reg <= it.target_reg;
        in_source_reg <= it.source_reg;
        in_cond_code  <= it.cond_code;
        in_flag_sel   <= it.flag_sel;
        do @(posedge clk); while (in_stall);
        alu.note_instruction(it);
    endtask

    // Result side: stall for a drawn number of cycles, then take and check one beat
    initial begin
        int      hold;
        t_result got;
        wait (rst_n === 1'b1);
        forever begin
            hold = out_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = '{acc_out: acc_out, x_out: x_out, y_out: y_out, status_out: status_out,
                    mem_value: mem_value, mem_write: mem_write, branch_taken: branch_taken};
            alu.check_step_result(got);
        end
    end

    initial begin
        alu = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: overflow and carry edges, every operation, the do-nothing cases
        issue_instruction(instr(OP_LD,   8'h7F, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_ADC,  8'h01, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_ADC,  8'hFF, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_SBC,  8'h80, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_AND,  8'h0F, REG_MEM, REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_ORA,  8'hF0, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_EOR,  8'hFF, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_BIT,  8'hC0, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_LD,   8'hFF, REG_X,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_CMP,  8'hFF, REG_X,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_CMP,  8'h12, REG_MEM, REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_LD,   8'h55, REG_MEM, REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_ASL,  8'h00, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_ROL,  8'h81, REG_MEM, REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_LSR,  8'h01, REG_X,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_ROR,  8'h00, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_INC,  8'hFF, REG_MEM, REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_DEC,  8'h00, REG_Y,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_INC,  8'h00, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_XFER, 8'h00, REG_X,   REG_Y, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_XFER, 8'h00, REG_MEM, REG_MEM, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_SETF, 8'h00, REG_A,   REG_A, CC_C_CLR, FS_B));
        issue_instruction(instr(OP_SETF, 8'h00, REG_A,   REG_A, CC_C_CLR, FSEL_SPARE_LAST));
        issue_instruction(instr(OP_CLRF, 8'h00, REG_A,   REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OP_BRTEST, 8'h00, REG_A, REG_A, CC_C_CLR, FS_C));
        issue_instruction(instr(OPC_SPARE_LAST, 8'hFF, REG_MEM, REG_MEM, CC_V_CLR,
                                FSEL_SPARE_LAST));

        // Random: each chunk picks its own idling mix, including none at all
        for (int c = 0; c < RANDOM_CHUNKS; c++) begin
            in_idle  = 1'($urandom_range(0, 1));
            out_idle = 1'($urandom_range(0, 1));
            for (int i = 0; i < CHUNK_BEATS; i++)
                issue_instruction(random_instr());
        end
        in_valid <= 1'b0;

        // Drain outstanding beats, then give the pipe time to show any stray one
        while (alu.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (alu.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
